[rtl/core/f3p_pkg.sv]
// f3p_pkg: widths, register reset value, row codes and the frame record
// shared by the frame-from-three-points pipeline. No dependencies.
`default_nettype none

package f3p_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int EDGE_W  = 33;
    localparam int UNIT_W  = 18;
    localparam int DOT_W   = 36;
    localparam int T_W     = 53;
    localparam int FRAC_W  = 16;
    localparam int LIMIT_W = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65529;

    // normalizer internals
    localparam int NORM_W = 31;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = 17;
    localparam int NUM_W  = 48;

    // row codes
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;
    localparam logic [1:0] ROW_T = 2'd3;

    // one finished frame: four rows of three entries, or collinear
    typedef struct packed {
        logic                           coll;
        logic [3:0][2:0][COORD_W-1:0]   ent;
    } t_frame;

endpackage

`default_nettype wire

[rtl/core/f3p_isqrt.sv]
// f3p_isqrt: pipelined integer square root, one result bit per stage.
// Depends on f3p_pkg for the operand and root widths.
`default_nettype none

module f3p_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [f3p_pkg::SQ_W-1:0]    i_x,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [f3p_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]           o_side
);
    import f3p_pkg::*;

    localparam int STEPS = SQ_W / 2;

    logic [SQ_W-1:0]   r_x  [STEPS];
    logic [SQ_W-1:0]   r_r  [STEPS];
    logic              r_v  [STEPS];
    logic [SIDE_W-1:0] r_sd [STEPS];

    genvar k;
    for (k = 0; k < STEPS; k++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0]   px, pr, trial, n_x, n_r;
        logic              pv;
        logic [SIDE_W-1:0] ps;

        if (k == 0) begin : g_first
            assign px = i_x;
            assign pr = '0;
            assign pv = i_valid;
            assign ps = i_side;
        end else begin : g_next
            assign px = r_x[k-1];
            assign pr = r_r[k-1];
            assign pv = r_v[k-1];
            assign ps = r_sd[k-1];
        end

        // trial subtract of the next root bit
        always_comb begin
            trial = pr + BIT;
            if (px >= trial) begin
                n_x = px - trial;
                n_r = (pr >> 1) + BIT;
            end else begin
                n_x = px;
                n_r = pr >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]  <= n_x;
                r_r[k]  <= n_r;
                r_sd[k] <= ps;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_r[STEPS-1][ROOT_W-1:0];
    assign o_side  = r_sd[STEPS-1];

endmodule

`default_nettype wire

[rtl/core/f3p_div.sv]
// f3p_div: three-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage. Depends on f3p_pkg for widths.
`default_nettype none

module f3p_div #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [f3p_pkg::NUM_W-1:0]   i_num [3],
    input  logic [f3p_pkg::ROOT_W-1:0]  i_len,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [f3p_pkg::QUO_W-1:0]   o_quo [3],
    output logic [SIDE_W-1:0]           o_side
);
    import f3p_pkg::*;

    logic [NUM_W-1:0]  r_rem [QUO_W][3];
    logic [QUO_W-1:0]  r_q   [QUO_W][3];
    logic [ROOT_W-1:0] r_len [QUO_W];
    logic              r_v   [QUO_W];
    logic [SIDE_W-1:0] r_sd  [QUO_W];

    genvar j;
    for (j = 0; j < QUO_W; j++) begin : g_step
        localparam int QB = QUO_W - 1 - j;
        logic [NUM_W-1:0]  prem [3];
        logic [QUO_W-1:0]  pq   [3];
        logic [NUM_W-1:0]  n_rem [3];
        logic [QUO_W-1:0]  n_q   [3];
        logic [ROOT_W-1:0] plen;
        logic [NUM_W:0]    dvs;
        logic              pv;
        logic [SIDE_W-1:0] ps;

        if (j == 0) begin : g_first
            assign prem = i_num;
            assign pq   = '{default: '0};
            assign plen = i_len;
            assign pv   = i_valid;
            assign ps   = i_side;
        end else begin : g_next
            assign prem = r_rem[j-1];
            assign pq   = r_q[j-1];
            assign plen = r_len[j-1];
            assign pv   = r_v[j-1];
            assign ps   = r_sd[j-1];
        end

        // compare and subtract the shifted divisor in each lane
        always_comb begin
            dvs = (NUM_W + 1)'(plen) << QB;
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, prem[i]} >= dvs) begin
                    n_rem[i] = prem[i] - dvs[NUM_W-1:0];
                    n_q[i]   = pq[i] | (QUO_W'(1) << QB);
                end else begin
                    n_rem[i] = prem[i];
                    n_q[i]   = pq[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_len[j] <= plen;
                r_sd[j]  <= ps;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_q[QUO_W-1];
    assign o_side  = r_sd[QUO_W-1];

endmodule

`default_nettype wire

[rtl/core/f3p_unitize.sv]
// f3p_unitize: pipelined vector normalizer to Q16 unit length, built from
// magnitude scaling, sum of squares, f3p_isqrt and f3p_div. Uses f3p_pkg.
`default_nettype none

module f3p_unitize #(
    parameter int VEC_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [VEC_W-1:0]            i_vec [3],
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic signed [f3p_pkg::UNIT_W-1:0]  o_unit [3],
    output logic [SIDE_W-1:0]                  o_side
);
    import f3p_pkg::*;

    localparam int PW         = $clog2(VEC_W);
    localparam int SQ_SIDE_W  = 3 * NORM_W + 3 + 1 + SIDE_W;
    localparam int DIV_SIDE_W = 3 + 1 + SIDE_W;
    localparam logic [PW-1:0] TOP_POS = PW'(NORM_W - 1);

    // stage 1: magnitudes and signs
    logic             r1_v;
    logic [VEC_W-1:0] r1_mag [3];
    logic [2:0]       r1_neg;
    logic [SIDE_W-1:0] r1_sd;
    logic [VEC_W-1:0] n1_mag [3];
    logic [2:0]       n1_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_neg[i] = i_vec[i][VEC_W-1];
            n1_mag[i] = n1_neg[i] ? VEC_W'(-i_vec[i]) : VEC_W'(i_vec[i]);
        end
    end

    // stage 2: leading one of the largest magnitude
    logic             r2_v;
    logic [VEC_W-1:0] r2_mag [3];
    logic [2:0]       r2_neg;
    logic [PW-1:0]    r2_p;
    logic             r2_ok;
    logic [SIDE_W-1:0] r2_sd;
    logic [VEC_W-1:0] n2_or;
    logic [PW-1:0]    n2_p;

    always_comb begin
        n2_or = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n2_p  = '0;
        for (int k = 0; k < VEC_W; k++) begin
            if (n2_or[k]) n2_p = PW'(k);
        end
    end

    // stage 3: scale so the largest lands in [2^30, 2^31)
    logic              r3_v;
    logic [NORM_W-1:0] r3_nm [3];
    logic [2:0]        r3_neg;
    logic              r3_ok;
    logic [SIDE_W-1:0] r3_sd;
    logic [VEC_W-1:0]  n3_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_p > TOP_POS) begin
                n3_sh[i] = r2_mag[i] >> (r2_p - TOP_POS);
            end else begin
                n3_sh[i] = r2_mag[i] << (TOP_POS - r2_p);
            end
        end
    end

    // stage 4: squares
    logic                r4_v;
    logic [2*NORM_W-1:0] r4_sq [3];
    logic [NORM_W-1:0]   r4_nm [3];
    logic [2:0]          r4_neg;
    logic                r4_ok;
    logic [SIDE_W-1:0]   r4_sd;

    // stage 5: sum of squares
    logic              r5_v;
    logic [SQ_W-1:0]   r5_s;
    logic [NORM_W-1:0] r5_nm [3];
    logic [2:0]        r5_neg;
    logic              r5_ok;
    logic [SIDE_W-1:0] r5_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag <= n1_mag;
            r1_neg <= n1_neg;
            r1_sd  <= i_side;
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r2_p   <= n2_p;
            r2_ok  <= (n2_or != '0);
            r2_sd  <= r1_sd;
            for (int i = 0; i < 3; i++) begin
                r3_nm[i] <= n3_sh[i][NORM_W-1:0];
                r4_sq[i] <= r3_nm[i] * r3_nm[i];
            end
            r3_neg <= r2_neg;
            r3_ok  <= r2_ok;
            r3_sd  <= r2_sd;
            r4_nm  <= r3_nm;
            r4_neg <= r3_neg;
            r4_ok  <= r3_ok;
            r4_sd  <= r3_sd;
            r5_s   <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
            r5_nm  <= r4_nm;
            r5_neg <= r4_neg;
            r5_ok  <= r4_ok;
            r5_sd  <= r4_sd;
        end
    end

    // square root of the sum, scaled values ride along
    logic                 sq_v;
    logic [ROOT_W-1:0]    sq_len;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic [NORM_W-1:0]    sq_nm [3];
    logic [2:0]           sq_neg;
    logic                 sq_ok;
    logic [SIDE_W-1:0]    sq_sd;

    f3p_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_v),
        .i_x     (r5_s),
        .i_side  ({r5_nm[0], r5_nm[1], r5_nm[2], r5_neg, r5_ok, r5_sd}),
        .o_valid (sq_v),
        .o_root  (sq_len),
        .o_side  (sq_side)
    );

    assign {sq_nm[0], sq_nm[1], sq_nm[2], sq_neg, sq_ok, sq_sd} = sq_side;

    // stage 6: rounded dividends
    logic              r6_v;
    logic [NUM_W-1:0]  r6_num [3];
    logic [ROOT_W-1:0] r6_len;
    logic [2:0]        r6_neg;
    logic              r6_ok;
    logic [SIDE_W-1:0] r6_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_num[i] <= NUM_W'({sq_nm[i], {FRAC_W{1'b0}}}) + NUM_W'(sq_len >> 1);
            end
            r6_len <= sq_len;
            r6_neg <= sq_neg;
            r6_ok  <= sq_ok;
            r6_sd  <= sq_sd;
        end
    end

    // per-component division by the length
    logic                  dv_v;
    logic [QUO_W-1:0]      dv_q [3];
    logic [DIV_SIDE_W-1:0] dv_side;
    logic [2:0]            dv_neg;
    logic                  dv_ok;
    logic [SIDE_W-1:0]     dv_sd;

    f3p_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_len   (r6_len),
        .i_side  ({r6_neg, r6_ok, r6_sd}),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_side  (dv_side)
    );

    assign {dv_neg, dv_ok, dv_sd} = dv_side;

    // stage 7: restore signs
    logic                     r7_v;
    logic                     r7_ok;
    logic signed [UNIT_W-1:0] r7_unit [3];
    logic [SIDE_W-1:0]        r7_sd;
    logic signed [UNIT_W-1:0] n7_unit [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_unit[i] = dv_neg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (i_en) begin
            r7_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_ok   <= dv_ok;
            r7_unit <= n7_unit;
            r7_sd   <= dv_sd;
        end
    end

    assign o_valid = r7_v;
    assign o_ok    = r7_ok;
    assign o_unit  = r7_unit;
    assign o_side  = r7_sd;

endmodule

`default_nettype wire

[rtl/core/f3p_row_out.sv]
// f3p_row_out: output register that plays one frame out as four rows, or
// one collinear row, and holds the pipeline meanwhile. Uses f3p_pkg.
`default_nettype none

module f3p_row_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  f3p_pkg::t_frame               i_frame,
    output logic                          o_adv,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_row_index,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_a,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_b,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_c,
    output logic                          o_collinear,
    output logic                          o_last_row
);
    import f3p_pkg::*;

    logic       r_busy;
    logic [1:0] r_row;
    t_frame     r_frame;
    logic       take;
    logic       last;

    // handshake and advance
    assign last  = r_frame.coll || (r_row == ROW_T);
    assign take  = r_busy && !i_stall;
    assign o_adv = !r_busy || (take && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_X;
        end else if (o_adv) begin
            r_busy <= i_valid;
            r_row  <= ROW_X;
        end else if (take) begin
            r_row  <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_frame <= i_frame;
        end
    end

    // row select, collinear rows carry zeros
    assign o_valid     = r_busy;
    assign o_row_index = r_row;
    assign o_entry_a   = r_frame.coll ? '0 : r_frame.ent[r_row][0];
    assign o_entry_b   = r_frame.coll ? '0 : r_frame.ent[r_row][1];
    assign o_entry_c   = r_frame.coll ? '0 : r_frame.ent[r_row][2];
    assign o_collinear = r_frame.coll;
    assign o_last_row  = last;

endmodule

`default_nettype wire

[rtl/core/frame_from_three_points.sv]
// frame_from_three_points: a new request is taken only while the pipeline advances,
// which the single row output port holds back while it plays out four rows per frame;
// collinear requests play out one row each and can be taken every cycle while i_stall is low.
// Reset is synchronous active low: clears all stage valid bits and the output
// register's busy flag and row, and loads the collinear limit with its default.
`default_nettype none

module frame_from_three_points (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [f3p_pkg::LIMIT_W-1:0]        i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_origin_y,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_origin_z,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_axis_point_x,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_axis_point_y,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_axis_point_z,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_plane_point_x,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_plane_point_y,
    input  logic signed [f3p_pkg::COORD_W-1:0] i_plane_point_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_row_index,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_a,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_b,
    output logic signed [f3p_pkg::COORD_W-1:0] o_entry_c,
    output logic                               o_collinear,
    output logic                               o_last_row
);
    import f3p_pkg::*;

    localparam int TP_W   = UNIT_W + DOT_W;
    localparam int CP_W   = 2 * UNIT_W;
    localparam int DIF_W  = CP_W + 1;
    localparam int T_SIDE = 3 * UNIT_W + 3 * COORD_W + 1;

    logic w_adv;

    // collinear limit register
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_stall = !w_adv;

    // first stage: axis point minus origin and plane point minus axis point
    logic signed [COORD_W-1:0] w_o [3];
    logic signed [COORD_W-1:0] w_a [3];
    logic signed [COORD_W-1:0] w_p [3];
    logic                      r_e_v;
    logic signed [EDGE_W-1:0]  r_e1d [3];
    logic signed [EDGE_W-1:0]  r_e2d [3];
    logic [COORD_W-1:0]        r_e_org [3];

    assign w_o = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_a = '{i_axis_point_x, i_axis_point_y, i_axis_point_z};
    assign w_p = '{i_plane_point_x, i_plane_point_y, i_plane_point_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_adv) begin
            r_e_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e1d[i]   <= EDGE_W'(w_a[i]) - EDGE_W'(w_o[i]);
                r_e2d[i]   <= EDGE_W'(w_p[i]) - EDGE_W'(w_a[i]);
                r_e_org[i] <= w_o[i];
            end
        end
    end

    // unit edges, origin split across the two sidebands
    logic                      u1_v, u1_ok, u2_ok;
    logic signed [UNIT_W-1:0]  u1 [3];
    logic signed [UNIT_W-1:0]  u2 [3];
    logic [2*COORD_W-1:0]      u1_sd;
    logic [COORD_W-1:0]        u2_sd;

    f3p_unitize #(
        .VEC_W  (EDGE_W),
        .SIDE_W (2 * COORD_W)
    ) u_unit_e1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_e_v),
        .i_vec   (r_e1d),
        .i_side  ({r_e_org[0], r_e_org[1]}),
        .o_valid (u1_v),
        .o_ok    (u1_ok),
        .o_unit  (u1),
        .o_side  (u1_sd)
    );

    f3p_unitize #(
        .VEC_W  (EDGE_W),
        .SIDE_W (COORD_W)
    ) u_unit_e2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_e_v),
        .i_vec   (r_e2d),
        .i_side  (r_e_org[2]),
        .o_valid (),
        .o_ok    (u2_ok),
        .o_unit  (u2),
        .o_side  (u2_sd)
    );

    // dot product stages
    logic                      r_d1_v, r_d2_v, r_d3_v, r_d4_v;
    logic signed [DOT_W-1:0]   r_d1_prod [3];
    logic signed [UNIT_W-1:0]  r_d1_e1 [3], r_d2_e1 [3], r_d3_e1 [3], r_d4_e1 [3];
    logic signed [UNIT_W-1:0]  r_d1_e2 [3], r_d2_e2 [3], r_d3_e2 [3];
    logic                      r_d1_ok, r_d2_ok;
    logic [3*COORD_W-1:0]      r_d1_org, r_d2_org, r_d3_org, r_d4_org;
    logic signed [DOT_W-1:0]   r_d2_dot;
    logic signed [TP_W-1:0]    r_d3_tp [3];
    logic                      r_d3_coll, r_d4_coll;
    logic signed [T_W-1:0]     r_d4_t [3];
    logic [DOT_W-1:0]          n_d3_mag;
    logic                      n_d3_coll;
    logic signed [TP_W-1:0]    n_d4_e2w [3];
    logic signed [T_W-1:0]     n_d4_t [3];

    // collinearity test against the limit
    always_comb begin
        n_d3_mag  = r_d2_dot[DOT_W-1] ? DOT_W'(-r_d2_dot) : DOT_W'(r_d2_dot);
        n_d3_coll = !r_d2_ok || (n_d3_mag > DOT_W'({r_limit, {FRAC_W{1'b0}}}));
    end

    // orthogonal part: e2 * 2^32 - e1 * dot
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d4_e2w[i] = TP_W'(r_d3_e2[i]);
            n_d4_t[i]   = T_W'((n_d4_e2w[i] <<< (2 * FRAC_W)) - r_d3_tp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
            r_d4_v <= 1'b0;
        end else if (w_adv) begin
            r_d1_v <= u1_v;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
            r_d4_v <= r_d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_d1_prod[i] <= u1[i] * u2[i];
                r_d3_tp[i]   <= r_d2_e1[i] * r_d2_dot;
            end
            r_d1_e1   <= u1;
            r_d1_e2   <= u2;
            r_d1_ok   <= u1_ok && u2_ok;
            r_d1_org  <= {u1_sd, u2_sd};
            r_d2_dot  <= r_d1_prod[0] + r_d1_prod[1] + r_d1_prod[2];
            r_d2_e1   <= r_d1_e1;
            r_d2_e2   <= r_d1_e2;
            r_d2_ok   <= r_d1_ok;
            r_d2_org  <= r_d1_org;
            r_d3_e1   <= r_d2_e1;
            r_d3_e2   <= r_d2_e2;
            r_d3_coll <= n_d3_coll;
            r_d3_org  <= r_d2_org;
            r_d4_t    <= n_d4_t;
            r_d4_e1   <= r_d3_e1;
            r_d4_coll <= r_d3_coll;
            r_d4_org  <= r_d3_org;
        end
    end

    // second axis from the orthogonal part
    logic                      ut_v, ut_ok;
    logic signed [UNIT_W-1:0]  ut [3];
    logic [T_SIDE-1:0]         ut_side;
    logic signed [UNIT_W-1:0]  ut_e1 [3];
    logic [3*COORD_W-1:0]      ut_org;
    logic                      ut_coll;

    f3p_unitize #(
        .VEC_W  (T_W),
        .SIDE_W (T_SIDE)
    ) u_unit_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_d4_v),
        .i_vec   (r_d4_t),
        .i_side  ({r_d4_e1[0], r_d4_e1[1], r_d4_e1[2], r_d4_org, r_d4_coll}),
        .o_valid (ut_v),
        .o_ok    (ut_ok),
        .o_unit  (ut),
        .o_side  (ut_side)
    );

    assign {ut_e1[0], ut_e1[1], ut_e1[2], ut_org, ut_coll} = ut_side;

    // cross product stages
    logic                      r_c1_v, r_c2_v;
    logic signed [CP_W-1:0]    r_c1_cp [6];
    logic signed [UNIT_W-1:0]  r_c1_e1 [3];
    logic signed [UNIT_W-1:0]  r_c1_r [3];
    logic [3*COORD_W-1:0]      r_c1_org;
    logic                      r_c1_coll;
    t_frame                    r_c2_frame;
    logic signed [DIF_W-1:0]   n_c2_dif [3];
    logic [DIF_W-1:0]          n_c2_mag [3];
    logic [DIF_W-1:0]          n_c2_q [3];
    logic [COORD_W-1:0]        n_c2_qz [3];
    t_frame                    n_c2_frame;

    // difference of products rounded half away from zero, frame assembly
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c2_dif[k] = DIF_W'(r_c1_cp[2*k]) - DIF_W'(r_c1_cp[2*k+1]);
            n_c2_mag[k] = n_c2_dif[k][DIF_W-1] ? DIF_W'(-n_c2_dif[k]) : DIF_W'(n_c2_dif[k]);
            n_c2_q[k]   = (n_c2_mag[k] + DIF_W'(1 << (FRAC_W - 1))) >> FRAC_W;
            n_c2_qz[k]  = COORD_W'(n_c2_q[k]);
        end
        n_c2_frame.coll = r_c1_coll;
        for (int k = 0; k < 3; k++) begin
            n_c2_frame.ent[ROW_X][k] = COORD_W'(r_c1_e1[k]);
            n_c2_frame.ent[ROW_Y][k] = COORD_W'(r_c1_r[k]);
            n_c2_frame.ent[ROW_Z][k] = n_c2_dif[k][DIF_W-1] ? -n_c2_qz[k] : n_c2_qz[k];
        end
        n_c2_frame.ent[ROW_T][0] = r_c1_org[3*COORD_W-1:2*COORD_W];
        n_c2_frame.ent[ROW_T][1] = r_c1_org[2*COORD_W-1:COORD_W];
        n_c2_frame.ent[ROW_T][2] = r_c1_org[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (w_adv) begin
            r_c1_v <= ut_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1_cp[0] <= ut_e1[1] * ut[2];
            r_c1_cp[1] <= ut_e1[2] * ut[1];
            r_c1_cp[2] <= ut_e1[2] * ut[0];
            r_c1_cp[3] <= ut_e1[0] * ut[2];
            r_c1_cp[4] <= ut_e1[0] * ut[1];
            r_c1_cp[5] <= ut_e1[1] * ut[0];
            r_c1_e1    <= ut_e1;
            r_c1_r     <= ut;
            r_c1_org   <= ut_org;
            r_c1_coll  <= ut_coll || !ut_ok;
            r_c2_frame <= n_c2_frame;
        end
    end

    // row output register
    f3p_row_out u_row_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_c2_v),
        .i_frame     (r_c2_frame),
        .o_adv       (w_adv),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_row_index (o_row_index),
        .o_entry_a   (o_entry_a),
        .o_entry_b   (o_entry_b),
        .o_entry_c   (o_entry_c),
        .o_collinear (o_collinear),
        .o_last_row  (o_last_row)
    );

endmodule

`default_nettype wire
